>>> rtl/quaternion_to_rotation_matrix_defines.svh
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication on clk, quiet while rst_n is low.
`define QRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, quiet while rst_n is low.
`define QRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qrm_pkg.sv
`timescale 1ns / 1ps

package qrm_pkg;

  localparam int CompW    = 16;
  localparam int FracBits = 14;
  localparam int EntW     = FracBits + 2;

  typedef struct packed {
    logic signed [CompW-1:0] comp_w;
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } qrm_in_t;

  typedef struct packed {
    logic signed [EntW-1:0] col0_row0;
    logic signed [EntW-1:0] col0_row1;
    logic signed [EntW-1:0] col0_row2;
    logic signed [EntW-1:0] col1_row0;
    logic signed [EntW-1:0] col1_row1;
    logic signed [EntW-1:0] col1_row2;
    logic signed [EntW-1:0] col2_row0;
    logic signed [EntW-1:0] col2_row1;
    logic signed [EntW-1:0] col2_row2;
    logic                   invalid;
  } qrm_out_t;

endpackage

>>> rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, streaming.
// Input channel in_valid / in_stall / in_data carries one quaternion (w, x, y, z),
// signed integers of any common scale. Output channel out_valid / out_stall /
// out_data carries the nine column-major entries in signed Q1.14 and an invalid
// flag, set for the zero quaternion, whose entries are then all zero.
// A transfer happens on a rising edge with valid high and stall low.
// Pipeline of FracBits + 6 stages: products, sums, magnitudes, one
// restoring-division step per quotient bit for 16 bits, then rounding.
// Throughput: one quaternion per cycle while in_stall is low; the
// per-bit division stages, nine lanes wide, set the depth.
// When the receiver stalls, the output register holds its result and earlier
// stages keep filling until every stage is occupied; only then is in_stall
// raised. Reset (rst_n low, synchronous) empties the pipeline; items in flight
// are dropped and out_valid is low afterwards.
`timescale 1ns / 1ps
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qrm_pkg::qrm_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qrm_pkg::qrm_out_t  out_data
);
  import qrm_pkg::*;

  localparam int PW      = 2 * CompW;
  localparam int SW      = PW + 2;
  localparam int NW      = PW + 1;
  localparam int QW      = FracBits + 2;
  localparam int NDIV    = FracBits + 2;
  localparam int NST     = NDIV + 4;
  localparam int NENT    = 9;
  localparam int StgD0   = 3;
  localparam int StgOut  = NST - 1;
  localparam int LastDiv = NDIV - 1;
  localparam logic [QW-1:0] EntLim = QW'(2 ** FracBits);

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !out_stall || !(&v_r[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[StgOut];

  // products
  logic signed [CompW-1:0] cw, cx, cy, cz;
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, xw_r, yz_r, yw_r, zw_r;

  assign cw = in_data.comp_w;
  assign cx = in_data.comp_x;
  assign cy = in_data.comp_y;
  assign cz = in_data.comp_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww_r <= PW'(cw) * PW'(cw);
      xx_r <= PW'(cx) * PW'(cx);
      yy_r <= PW'(cy) * PW'(cy);
      zz_r <= PW'(cz) * PW'(cz);
      xy_r <= PW'(cx) * PW'(cy);
      xz_r <= PW'(cx) * PW'(cz);
      xw_r <= PW'(cx) * PW'(cw);
      yz_r <= PW'(cy) * PW'(cz);
      yw_r <= PW'(cy) * PW'(cw);
      zw_r <= PW'(cz) * PW'(cw);
    end
  end

  // numerators, off-diagonal ones doubled, and the quadrance
  logic signed [SW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_xw, e_yz, e_yw, e_zw;
  logic signed [SW-1:0] num_nxt [NENT];
  logic signed [SW-1:0] num_r   [NENT];
  logic [NW-1:0]        quad_nxt;
  logic [NW-1:0]        quad_r;

  always_comb begin
    e_ww = SW'(ww_r);
    e_xx = SW'(xx_r);
    e_yy = SW'(yy_r);
    e_zz = SW'(zz_r);
    e_xy = SW'(xy_r);
    e_xz = SW'(xz_r);
    e_xw = SW'(xw_r);
    e_yz = SW'(yz_r);
    e_yw = SW'(yw_r);
    e_zw = SW'(zw_r);
    num_nxt[0] = e_ww + e_xx - e_yy - e_zz;
    num_nxt[1] = (e_xy + e_zw) <<< 1;
    num_nxt[2] = (e_xz - e_yw) <<< 1;
    num_nxt[3] = (e_xy - e_zw) <<< 1;
    num_nxt[4] = e_ww - e_xx + e_yy - e_zz;
    num_nxt[5] = (e_yz + e_xw) <<< 1;
    num_nxt[6] = (e_xz + e_yw) <<< 1;
    num_nxt[7] = (e_yz - e_xw) <<< 1;
    num_nxt[8] = e_ww - e_xx - e_yy + e_zz;
    quad_nxt   = NW'(e_ww + e_xx + e_yy + e_zz);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_r  <= num_nxt;
      quad_r <= quad_nxt;
    end
  end

  // sign and magnitude
  logic [SW-1:0]   abs_nxt [NENT];
  logic [NW-1:0]   dvd_nxt [NENT];
  logic [NENT-1:0] sgn_nxt;
  logic [NW-1:0]   dvd_r   [NENT];
  logic [NENT-1:0] sgn2_r;
  logic [NW-1:0]   quad2_r;
  logic            inv2_r;

  always_comb begin
    for (int k = 0; k < NENT; k++) begin
      sgn_nxt[k] = num_r[k][SW-1];
      abs_nxt[k] = num_r[k][SW-1] ? -num_r[k] : num_r[k];
      dvd_nxt[k] = abs_nxt[k][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dvd_r   <= dvd_nxt;
      sgn2_r  <= sgn_nxt;
      quad2_r <= quad_r;
      inv2_r  <= (quad_r == '0);
    end
  end

  // restoring division, one quotient bit per stage
  logic [NW-1:0]   rem_r    [NDIV][NENT];
  logic [QW-1:0]   quo_r    [NDIV][NENT];
  logic [NENT-1:0] sgn_r    [NDIV];
  logic [NW-1:0]   quad_d_r [NDIV];
  logic            inv_d_r  [NDIV];

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [NW:0]     trial    [NENT];
    logic [QW-1:0]   quo_prev [NENT];
    logic [NENT-1:0] sgn_in;
    logic [NW-1:0]   quad_in;
    logic            inv_in;
    logic [NW:0]     diff     [NENT];
    logic [NENT-1:0] ge;
    logic [NW-1:0]   rem_nxt  [NENT];
    logic [QW-1:0]   quo_nxt  [NENT];

    if (g == 0) begin : g_src
      always_comb begin
        for (int k = 0; k < NENT; k++) begin
          trial[k]    = {1'b0, dvd_r[k]};
          quo_prev[k] = '0;
        end
        sgn_in  = sgn2_r;
        quad_in = quad2_r;
        inv_in  = inv2_r;
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < NENT; k++) begin
          trial[k]    = {rem_r[g-1][k], 1'b0};
          quo_prev[k] = quo_r[g-1][k];
        end
        sgn_in  = sgn_r[g-1];
        quad_in = quad_d_r[g-1];
        inv_in  = inv_d_r[g-1];
      end
    end

    always_comb begin
      for (int k = 0; k < NENT; k++) begin
        diff[k]    = trial[k] - {1'b0, quad_in};
        ge[k]      = (trial[k] >= {1'b0, quad_in});
        rem_nxt[k] = ge[k] ? diff[k][NW-1:0] : trial[k][NW-1:0];
        quo_nxt[k] = {quo_prev[k][QW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[StgD0+g]) begin
        rem_r[g]    <= rem_nxt;
        quo_r[g]    <= quo_nxt;
        sgn_r[g]    <= sgn_in;
        quad_d_r[g] <= quad_in;
        inv_d_r[g]  <= inv_in;
      end
    end
  end

  // round half up on the magnitude, clamp, apply sign
  logic [QW:0]            rnd_nxt [NENT];
  logic [QW-1:0]          mag_nxt [NENT];
  logic signed [EntW-1:0] ent_nxt [NENT];
  qrm_out_t               out_r;

  always_comb begin
    for (int k = 0; k < NENT; k++) begin
      rnd_nxt[k] = {1'b0, quo_r[LastDiv][k]} + (QW+1)'(1);
      mag_nxt[k] = rnd_nxt[k][QW:1];
      if (mag_nxt[k] > EntLim) begin
        mag_nxt[k] = EntLim;
      end
      if (inv_d_r[LastDiv]) begin
        ent_nxt[k] = '0;
      end else if (sgn_r[LastDiv][k]) begin
        ent_nxt[k] = -mag_nxt[k];
      end else begin
        ent_nxt[k] = mag_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[StgOut]) begin
      out_r.col0_row0 <= ent_nxt[0];
      out_r.col0_row1 <= ent_nxt[1];
      out_r.col0_row2 <= ent_nxt[2];
      out_r.col1_row0 <= ent_nxt[3];
      out_r.col1_row1 <= ent_nxt[4];
      out_r.col1_row2 <= ent_nxt[5];
      out_r.col2_row0 <= ent_nxt[6];
      out_r.col2_row1 <= ent_nxt[7];
      out_r.col2_row2 <= ent_nxt[8];
      out_r.invalid   <= inv_d_r[LastDiv];
    end
  end

  assign out_data = out_r;

  logic in_xfer;
  logic out_xfer;
  logic ent_all_zero;
  int   occ;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign occ      = $countones(v_r);
  assign ent_all_zero = (out_data.col0_row0 == '0) && (out_data.col0_row1 == '0) &&
                        (out_data.col0_row2 == '0) && (out_data.col1_row0 == '0) &&
                        (out_data.col1_row1 == '0) && (out_data.col1_row2 == '0) &&
                        (out_data.col2_row0 == '0) && (out_data.col2_row1 == '0) &&
                        (out_data.col2_row2 == '0);

  `QRM_ASSERT_SAME(a_inv_zero, out_valid && out_data.invalid, ent_all_zero, "invalid with entries")
  `QRM_ASSERT_SAME(a_stall_full, in_stall, &v_r, "input held back with an empty stage")
  `QRM_ASSERT_NEXT(a_occ, 1'b1, occ == $past(occ) + $past(in_xfer) - $past(out_xfer), "item lost")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qrm_pkg::*;

  localparam int Latency    = 20;
  localparam int StuckLimit = 3000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  qrm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qrm_out_t out_data;

  qrm_out_t pending_matrices[$];

  int  quats_sent      = 0;
  int  quats_accepted  = 0;
  int  matrices_seen   = 0;
  int  zero_quats      = 0;
  int  in_stall_cycles = 0;
  int  mismatches      = 0;
  int  strays          = 0;
  int  stuck_cycles    = 0;
  int  burst_left      = 0;
  int  rx_hold_req     = 0;
  bit  gaps_on         = 1'b1;

  quaternion_to_rotation_matrix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [EntW-1:0] fixed_ratio(longint num, longint den, int shift);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << shift) / den + 1) >>> 1;
    if (q > (longint'(1) << FracBits)) q = longint'(1) << FracBits;
    return EntW'((num < 0) ? -q : q);
  endfunction

  function automatic qrm_out_t rotation_of(qrm_in_t q);
    longint w, x, y, z, quad;
    qrm_out_t m;
    w = q.comp_w;
    x = q.comp_x;
    y = q.comp_y;
    z = q.comp_z;
    quad = w * w + x * x + y * y + z * z;
    m = '0;
    if (quad == 0) begin
      m.invalid = 1'b1;
      return m;
    end
    m.col0_row0 = fixed_ratio(w * w + x * x - y * y - z * z, quad, FracBits + 1);
    m.col0_row1 = fixed_ratio(x * y + z * w, quad, FracBits + 2);
    m.col0_row2 = fixed_ratio(x * z - y * w, quad, FracBits + 2);
    m.col1_row0 = fixed_ratio(x * y - z * w, quad, FracBits + 2);
    m.col1_row1 = fixed_ratio(w * w - x * x + y * y - z * z, quad, FracBits + 1);
    m.col1_row2 = fixed_ratio(y * z + x * w, quad, FracBits + 2);
    m.col2_row0 = fixed_ratio(x * z + y * w, quad, FracBits + 2);
    m.col2_row1 = fixed_ratio(y * z - x * w, quad, FracBits + 2);
    m.col2_row2 = fixed_ratio(w * w - x * x - y * y + z * z, quad, FracBits + 1);
    return m;
  endfunction

  function automatic qrm_in_t make_quat(int w, int x, int y, int z);
    qrm_in_t q;
    q.comp_w = CompW'(w);
    q.comp_x = CompW'(x);
    q.comp_y = CompW'(y);
    q.comp_z = CompW'(z);
    return q;
  endfunction

  function automatic qrm_in_t random_quat();
    int corner_vals[8] = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};
    int c[4];
    int kind;
    int pick;
    kind = $urandom_range(0, 19);
    pick = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      if (kind < 11) begin
        c[i] = $urandom_range(0, 65535) - 32768;
      end else if (kind < 14) begin
        c[i] = $urandom_range(0, 8) - 4;
      end else if (kind < 16) begin
        c[i] = corner_vals[$urandom_range(0, 7)];
      end else if (kind < 18) begin
        c[i] = (i == pick) ? $urandom_range(0, 65535) - 32768 : 0;
      end else if (kind < 19) begin
        c[i] = $urandom_range(0, 511) - 256;
      end else begin
        c[i] = 0;
      end
    end
    return make_quat(c[0], c[1], c[2], c[3]);
  endfunction

  task automatic check_field(string field, logic signed [EntW-1:0] exp_v,
                             logic signed [EntW-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at matrix %0d, %s: expected %0d, got %0d",
                 matrices_seen, field, exp_v, act_v);
    end
  endtask

  task automatic check_matrix(qrm_out_t exp_m, qrm_out_t act_m);
    check_field("col0_row0", exp_m.col0_row0, act_m.col0_row0);
    check_field("col0_row1", exp_m.col0_row1, act_m.col0_row1);
    check_field("col0_row2", exp_m.col0_row2, act_m.col0_row2);
    check_field("col1_row0", exp_m.col1_row0, act_m.col1_row0);
    check_field("col1_row1", exp_m.col1_row1, act_m.col1_row1);
    check_field("col1_row2", exp_m.col1_row2, act_m.col1_row2);
    check_field("col2_row0", exp_m.col2_row0, act_m.col2_row0);
    check_field("col2_row1", exp_m.col2_row1, act_m.col2_row1);
    check_field("col2_row2", exp_m.col2_row2, act_m.col2_row2);
    check_field("invalid", EntW'(exp_m.invalid), EntW'(act_m.invalid));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_matrices.push_back(rotation_of(in_data));
        quats_accepted++;
        if (in_data == '0) zero_quats++;
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) begin
        matrices_seen++;
        if (pending_matrices.size() == 0) begin
          strays++;
          if (strays <= 10)
            $display("unexpected matrix transfer %0d: %p", matrices_seen, out_data);
        end else begin
          check_matrix(pending_matrices.pop_front(), out_data);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("watchdog: no transfer for %0d cycles, %0d matrices outstanding",
                   stuck_cycles, pending_matrices.size());
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : rx_stall_gen
    int hold_left;
    int mode_left;
    int stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(8, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_quat(qrm_in_t q);
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
    quats_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_quaternions();
    int corners[23][4] = '{
      '{0, 0, 0, 0}, '{1, 0, 0, 0}, '{-1, 0, 0, 0}, '{32767, 0, 0, 0},
      '{-32768, 0, 0, 0}, '{0, -32768, 0, 0}, '{0, 0, -32768, 0},
      '{0, 0, 0, -32768}, '{0, 32767, 0, 0},
      '{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767, 32767},
      '{32767, -32768, 32767, -32768}, '{-32768, 32767, -32768, 32767},
      '{1, 1, 1, 1}, '{1, -1, 1, -1}, '{0, 1, 1, 0}, '{0, 0, 1, 1},
      '{3, 4, 0, 0}, '{1, 2, 3, 4}, '{32767, 1, 0, 0}, '{1, 32767, -32768, 0},
      '{-5, 7, -11, 13}, '{0, 0, 0, 1}
    };
    for (int i = 0; i < 23; i++)
      send_quat(make_quat(corners[i][0], corners[i][1], corners[i][2], corners[i][3]));
    wait_for_drain();
  endtask

  task automatic test_random_mix();
    for (int seg = 0; seg < 7; seg++) begin
      gaps_on = (seg % 2 == 0) || ($urandom_range(0, 1) == 1);
      repeat (150) send_quat(random_quat());
    end
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_full_pipeline();
    rx_hold_req = 250;
    gaps_on = 1'b0;
    repeat (80) send_quat(random_quat());
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (200) send_quat(random_quat());
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_quaternions();
    test_random_mix();
    test_full_pipeline();
    test_back_to_back();

    repeat (2 * Latency) @(posedge clk);
    if (pending_matrices.size() != 0)
      $display("%0d expected matrices never arrived", pending_matrices.size());

    $display("summary: %0d quaternions sent, %0d transferred (%0d zero), %0d matrices checked",
             quats_sent, quats_accepted, zero_quats, matrices_seen);
    $display("summary: %0d cycles of input backpressure, %0d field mismatches, %0d strays",
             in_stall_cycles, mismatches, strays);
    if (mismatches == 0 && strays == 0 && pending_matrices.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/qrm_pkg.sv
rtl/quaternion_to_rotation_matrix.sv
tb/testbench.sv
